### hdl/rqi_pkg.sv
// shared constants, types and a saturating add helper for the ray / quadric intersector
package rqi_pkg;

  localparam int CW   = 32;          // coordinate and coefficient width
  localparam int FB   = 16;          // fraction bits
  localparam int SW   = 61;          // saturated intermediate width
  localparam int BW   = CW + 1;      // narrow multiplier operand width
  localparam int KW   = 32;          // one packed coefficient half
  localparam int RW64 = 64;          // configuration register width

  localparam int NUM_REG = 5;

  typedef enum logic [2:0] {
    REG_XX_YY     = 3'd0,
    REG_ZZ_XY     = 3'd1,
    REG_XZ_YZ     = 3'd2,
    REG_LIN_X_Y   = 3'd3,
    REG_LIN_Z_K0  = 3'd4
  } reg_idx_t;

  typedef logic signed [SW-1:0] sval_t;

  localparam sval_t SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam sval_t SMIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] oz;
    logic signed [CW-1:0] ux;
    logic signed [CW-1:0] uy;
    logic signed [CW-1:0] uz;
  } ray_t;

  typedef struct packed {
    sval_t a;
    sval_t b;
    sval_t c;
    logic  azero;
    logic  acneg;
    logic  ok;
  } qd_t;

  typedef struct packed {
    logic azero;
    logic ok;
    logic bnz;
    logic neg1;
    logic neg2;
  } fl_t;

  // saturating add over the intermediate range
  function automatic sval_t sadd(input sval_t x, input sval_t y);
    logic signed [SW:0] s;
    s = {x[SW-1], x} + {y[SW-1], y};
    if (s[SW] != s[SW-1]) return s[SW] ? SMIN : SMAX;
    return s[SW-1:0];
  endfunction

endpackage

### hdl/ray_quadric_intersect_unit.sv
// ray against general quadric surface: nearest forward hit point, fully pipelined
// throughput: one ray per cycle; the whole pipeline holds while a result is not taken
// latency is set by the 63-stage square root and the 80-stage dividers, one bit per stage
// reset: clears all valid bits and the five coefficient registers to zero
// coefficient writes are taken at any time and ready is always high
module ray_quadric_intersect_unit (
  input  logic                            clk,
  input  logic                            rst,
  // fields from bit 0: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [6*rqi_pkg::CW-1:0]        s_axis_tdata,
  // fields from bit 0: hit_x, hit_y, hit_z
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [3*rqi_pkg::CW-1:0]        m_axis_tdata,
  // fields from bit 0: hit
  output logic [0:0]                      m_axis_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [rqi_pkg::RW64-1:0]        cfg_data
);
  import rqi_pkg::*;

  // pipeline geometry
  localparam int NL1     = 27;                   // first level products
  localparam int NL2     = 18;                   // second level products
  localparam int NA      = 6;                    // terms of a
  localparam int NB      = 9;                    // terms of b
  localparam int NACC    = 10;                   // terms of c, longest chain
  localparam int NT      = NA + NB + NACC;
  localparam int ST_X    = 3;
  localparam int ST_MAG  = ST_X + 3 + NACC;
  localparam int ST_DISC = ST_MAG + 3;
  localparam int RT_N    = 63;                   // root bits
  localparam int ST_NUM  = ST_DISC + RT_N + 1;
  localparam int DVN     = 64 + FB;              // dividend bits
  localparam int ST_SEL  = ST_NUM + 1 + DVN + 2;
  localparam int ST_OUT  = ST_SEL + 3;
  localparam int DW      = 124;                  // discriminant width
  localparam int RW      = 127;                  // root trial width
  localparam int NW      = 64;                   // numerator width
  localparam int DENW    = SW + 1;               // denominator width
  localparam sval_t TEPS = sval_t'((64'(1) << FB) >> 10);
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // ---------------------------------------------------------------- control
  logic [ST_OUT:0] vld;
  logic            en;

  // a single enable moves every stage; it drops only while the output register is full and not taken
  assign en            = !vld[ST_OUT] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[ST_OUT];
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST_OUT-1:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------- coefficients
  logic [RW64-1:0] coef [0:NUM_REG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REG; i++) coef[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_XX_YY:    coef[REG_XX_YY]    <= cfg_data;
        REG_ZZ_XY:    coef[REG_ZZ_XY]    <= cfg_data;
        REG_XZ_YZ:    coef[REG_XZ_YZ]    <= cfg_data;
        REG_LIN_X_Y:  coef[REG_LIN_X_Y]  <= cfg_data;
        REG_LIN_Z_K0: coef[REG_LIN_Z_K0] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [KW-1:0] kxx, kyy, kzz, kxy, kxz, kyz, kx, ky, kz, k0;

  // first named coefficient sits in the low half
  assign kxx = $signed(coef[REG_XX_YY][KW-1:0]);
  assign kyy = $signed(coef[REG_XX_YY][2*KW-1:KW]);
  assign kzz = $signed(coef[REG_ZZ_XY][KW-1:0]);
  assign kxy = $signed(coef[REG_ZZ_XY][2*KW-1:KW]);
  assign kxz = $signed(coef[REG_XZ_YZ][KW-1:0]);
  assign kyz = $signed(coef[REG_XZ_YZ][2*KW-1:KW]);
  assign kx  = $signed(coef[REG_LIN_X_Y][KW-1:0]);
  assign ky  = $signed(coef[REG_LIN_X_Y][2*KW-1:KW]);
  assign kz  = $signed(coef[REG_LIN_Z_K0][KW-1:0]);
  assign k0  = $signed(coef[REG_LIN_Z_K0][2*KW-1:KW]);

  // ---------------------------------------------------------------- ray delay line
  ray_t ray_p [0:ST_OUT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ray_p[0].ox <= s_axis_tdata[0*CW +: CW];
      ray_p[0].oy <= s_axis_tdata[1*CW +: CW];
      ray_p[0].oz <= s_axis_tdata[2*CW +: CW];
      ray_p[0].ux <= s_axis_tdata[3*CW +: CW];
      ray_p[0].uy <= s_axis_tdata[4*CW +: CW];
      ray_p[0].uz <= s_axis_tdata[5*CW +: CW];
      for (int i = 1; i < ST_OUT; i++) ray_p[i] <= ray_p[i-1];
    end
  end

  // ---------------------------------------------------------------- first level products
  sval_t                l1_a [0:NL1-1];
  logic signed [BW-1:0] l1_b [0:NL1-1];
  sval_t                l1_p [0:NL1-1];

  always_comb begin
    ray_t r;
    r = ray_p[0];
    // quadratic terms of a
    l1_a[0]  = SW'(kxx);        l1_b[0]  = BW'(r.ux);
    l1_a[1]  = SW'(kyy);        l1_b[1]  = BW'(r.uy);
    l1_a[2]  = SW'(kzz);        l1_b[2]  = BW'(r.uz);
    l1_a[3]  = SW'(kxy);        l1_b[3]  = BW'(r.ux);
    l1_a[4]  = SW'(kxz);        l1_b[4]  = BW'(r.ux);
    l1_a[5]  = SW'(kyz);        l1_b[5]  = BW'(r.uy);
    // doubled squares for b
    l1_a[6]  = SW'(kxx) <<< 1;  l1_b[6]  = BW'(r.ox);
    l1_a[7]  = SW'(kyy) <<< 1;  l1_b[7]  = BW'(r.oy);
    l1_a[8]  = SW'(kzz) <<< 1;  l1_b[8]  = BW'(r.oz);
    // mixed origin and direction products
    l1_a[9]  = SW'(r.ox);       l1_b[9]  = BW'(r.uy);
    l1_a[10] = SW'(r.oy);       l1_b[10] = BW'(r.ux);
    l1_a[11] = SW'(r.ox);       l1_b[11] = BW'(r.uz);
    l1_a[12] = SW'(r.oz);       l1_b[12] = BW'(r.ux);
    l1_a[13] = SW'(r.oy);       l1_b[13] = BW'(r.uz);
    l1_a[14] = SW'(r.oz);       l1_b[14] = BW'(r.uy);
    // linear part of b
    l1_a[15] = SW'(kx);         l1_b[15] = BW'(r.ux);
    l1_a[16] = SW'(ky);         l1_b[16] = BW'(r.uy);
    l1_a[17] = SW'(kz);         l1_b[17] = BW'(r.uz);
    // quadratic terms of c
    l1_a[18] = SW'(kxx);        l1_b[18] = BW'(r.ox);
    l1_a[19] = SW'(kyy);        l1_b[19] = BW'(r.oy);
    l1_a[20] = SW'(kzz);        l1_b[20] = BW'(r.oz);
    l1_a[21] = SW'(kxy);        l1_b[21] = BW'(r.ox);
    l1_a[22] = SW'(kxz);        l1_b[22] = BW'(r.ox);
    l1_a[23] = SW'(kyz);        l1_b[23] = BW'(r.oy);
    // linear part of c
    l1_a[24] = SW'(kx);         l1_b[24] = BW'(r.ox);
    l1_a[25] = SW'(ky);         l1_b[25] = BW'(r.oy);
    l1_a[26] = SW'(kz);         l1_b[26] = BW'(r.oz);
  end

  for (genvar i = 0; i < NL1; i++) begin : g_l1
    rqi_qmul u_mul (.clk(clk), .en(en), .a(l1_a[i]), .b(l1_b[i]), .p(l1_p[i]));
  end

  // ---------------------------------------------------------------- cross sums, second level
  sval_t                l2_a  [0:NL2-1];
  logic signed [BW-1:0] l2_b  [0:NL2-1];
  sval_t                l2_p  [0:NL2-1];
  sval_t                lin3  [0:5];
  sval_t                lin4  [0:5];
  sval_t                lin5  [0:5];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) l2_a[i] <= l1_p[i];
      l2_a[9]  <= sadd(l1_p[9],  l1_p[10]);
      l2_a[10] <= sadd(l1_p[11], l1_p[12]);
      l2_a[11] <= sadd(l1_p[13], l1_p[14]);
      for (int i = 0; i < 6; i++) l2_a[12+i] <= l1_p[18+i];
      for (int i = 0; i < 3; i++) begin
        lin3[i]   <= l1_p[15+i];
        lin3[3+i] <= l1_p[24+i];
      end
      lin4 <= lin3;
      lin5 <= lin4;
    end
  end

  always_comb begin
    ray_t r;
    r = ray_p[ST_X];
    l2_b[0]  = BW'(r.ux);  l2_b[1]  = BW'(r.uy);  l2_b[2]  = BW'(r.uz);
    l2_b[3]  = BW'(r.uy);  l2_b[4]  = BW'(r.uz);  l2_b[5]  = BW'(r.uz);
    l2_b[6]  = BW'(r.ux);  l2_b[7]  = BW'(r.uy);  l2_b[8]  = BW'(r.uz);
    // cross sums scaled by their coefficients
    l2_b[9]  = BW'(kxy);   l2_b[10] = BW'(kxz);   l2_b[11] = BW'(kyz);
    l2_b[12] = BW'(r.ox);  l2_b[13] = BW'(r.oy);  l2_b[14] = BW'(r.oz);
    l2_b[15] = BW'(r.oy);  l2_b[16] = BW'(r.oz);  l2_b[17] = BW'(r.oz);
  end

  for (genvar i = 0; i < NL2; i++) begin : g_l2
    rqi_qmul u_mul (.clk(clk), .en(en), .a(l2_a[i]), .b(l2_b[i]), .p(l2_p[i]));
  end

  // ---------------------------------------------------------------- ordered saturating sums
  // terms of a, then b, then c, each chain added strictly left to right
  sval_t tm5   [0:NT-1];
  sval_t tm    [0:NACC-2][0:NT-1];
  sval_t acc_a [0:NACC-1];
  sval_t acc_b [0:NACC-1];
  sval_t acc_c [0:NACC-1];

  always_comb begin
    for (int i = 0; i < 12; i++) tm5[i] = l2_p[i];
    for (int i = 0; i < 3; i++)  tm5[12+i] = lin5[i];
    for (int i = 0; i < 6; i++)  tm5[15+i] = l2_p[12+i];
    for (int i = 0; i < 3; i++)  tm5[21+i] = lin5[3+i];
    tm5[NT-1] = SW'(k0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tm[0]    <= tm5;
      acc_a[0] <= tm5[0];
      acc_b[0] <= tm5[NA];
      acc_c[0] <= tm5[NA+NB];
    end
  end

  for (genvar k = 1; k < NACC; k++) begin : g_acc
    always_ff @(posedge clk) begin
      if (en) begin
        acc_a[k] <= (k < NA) ? sadd(acc_a[k-1], tm[k-1][k])    : acc_a[k-1];
        acc_b[k] <= (k < NB) ? sadd(acc_b[k-1], tm[k-1][NA+k]) : acc_b[k-1];
        acc_c[k] <= sadd(acc_c[k-1], tm[k-1][NA+NB+k]);
      end
    end
    if (k < NACC - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) tm[k] <= tm[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- discriminant
  qd_t             qd16, qd17, qd18;
  logic [SW-1:0]   ma, mb, mc;
  logic [63:0]     p_bll, p_all;
  logic [60:0]     p_blh, p_alh, p_ahl;
  logic [57:0]     p_bhh, p_ahh;
  logic [DW-1:0]   bb, ac4;

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes and signs
      qd16.a     <= acc_a[NACC-1];
      qd16.b     <= acc_b[NACC-1];
      qd16.c     <= acc_c[NACC-1];
      qd16.azero <= (acc_a[NACC-1] == '0);
      qd16.acneg <= acc_a[NACC-1][SW-1] ^ acc_c[NACC-1][SW-1];
      qd16.ok    <= 1'b0;
      ma <= acc_a[NACC-1][SW-1] ? SW'(-acc_a[NACC-1]) : acc_a[NACC-1];
      mb <= acc_b[NACC-1][SW-1] ? SW'(-acc_b[NACC-1]) : acc_b[NACC-1];
      mc <= acc_c[NACC-1][SW-1] ? SW'(-acc_c[NACC-1]) : acc_c[NACC-1];
      // partial products of b*b and a*c
      qd17  <= qd16;
      p_bll <= mb[31:0] * mb[31:0];
      p_blh <= mb[31:0] * mb[SW-1:32];
      p_bhh <= mb[SW-1:32] * mb[SW-1:32];
      p_all <= ma[31:0] * mc[31:0];
      p_alh <= ma[31:0] * mc[SW-1:32];
      p_ahl <= ma[SW-1:32] * mc[31:0];
      p_ahh <= ma[SW-1:32] * mc[SW-1:32];
      // reassemble, 4ac as a shift
      qd18 <= qd17;
      bb   <= (DW'(p_bhh) << 64) + (DW'(p_blh) << 33) + DW'(p_bll);
      ac4  <= ((DW'(p_ahh) << 64) + (DW'(p_alh) << 32) + (DW'(p_ahl) << 32)
              + DW'(p_all)) << 2;
    end
  end

  // ---------------------------------------------------------------- square root, one bit a stage
  logic [DW-1:0]   sq_rem  [0:RT_N];
  logic [RT_N-1:0] sq_root [0:RT_N];
  qd_t             qd_p    [0:RT_N];

  always_ff @(posedge clk) begin
    if (en) begin
      qd_p[0]    <= '{a: qd18.a, b: qd18.b, c: qd18.c, azero: qd18.azero,
                      acneg: qd18.acneg, ok: qd18.acneg || (ac4 <= bb)};
      sq_rem[0]  <= qd18.acneg ? bb + ac4 : bb - ac4;
      sq_root[0] <= '0;
    end
  end

  for (genvar j = 0; j < RT_N; j++) begin : g_sqrt
    localparam int BIT = RT_N - 1 - j;
    logic [RW-1:0] trial;
    // (r + 2^bit)^2 - r^2
    assign trial = (RW'(sq_root[j]) << (BIT + 1)) + (RW'(1) << (2 * BIT));
    always_ff @(posedge clk) begin
      if (en) begin
        qd_p[j+1] <= qd_p[j];
        if (RW'(sq_rem[j]) >= trial) begin
          sq_rem[j+1]  <= DW'(RW'(sq_rem[j]) - trial);
          sq_root[j+1] <= sq_root[j] | (RT_N'(1) << BIT);
        end else begin
          sq_rem[j+1]  <= sq_rem[j];
          sq_root[j+1] <= sq_root[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------- numerators, denominator
  logic signed [NW-1:0]   num1, num2;
  logic signed [DENW-1:0] den;
  fl_t                    fl83;
  logic signed [NW-1:0]   neg_b;

  assign neg_b = -NW'(qd_p[RT_N].b);

  always_ff @(posedge clk) begin
    if (en) begin
      fl83.azero <= qd_p[RT_N].azero;
      fl83.ok    <= qd_p[RT_N].ok;
      fl83.bnz   <= (qd_p[RT_N].b != '0);
      fl83.neg1  <= 1'b0;
      fl83.neg2  <= 1'b0;
      if (qd_p[RT_N].azero) begin
        // linear case: t = -c / b
        num1 <= -NW'(qd_p[RT_N].c);
        num2 <= -NW'(qd_p[RT_N].c);
        den  <= DENW'(qd_p[RT_N].b);
      end else begin
        num1 <= neg_b - $signed({1'b0, sq_root[RT_N]});
        num2 <= neg_b + $signed({1'b0, sq_root[RT_N]});
        den  <= DENW'(qd_p[RT_N].a) <<< 1;
      end
    end
  end

  // ---------------------------------------------------------------- two restoring dividers
  logic [DVN-1:0]  dv_n1 [0:DVN];
  logic [DVN-1:0]  dv_n2 [0:DVN];
  logic [DENW-1:0] dv_r1 [0:DVN];
  logic [DENW-1:0] dv_r2 [0:DVN];
  logic [DVN-1:0]  dv_q1 [0:DVN];
  logic [DVN-1:0]  dv_q2 [0:DVN];
  logic [DENW-1:0] dv_d  [0:DVN];
  fl_t             dv_fl [0:DVN];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_fl[0] <= '{azero: fl83.azero, ok: fl83.ok, bnz: fl83.bnz,
                    neg1: num1[NW-1] ^ den[DENW-1], neg2: num2[NW-1] ^ den[DENW-1]};
      dv_n1[0] <= {(num1[NW-1] ? NW'(-num1) : NW'(num1)), {FB{1'b0}}};
      dv_n2[0] <= {(num2[NW-1] ? NW'(-num2) : NW'(num2)), {FB{1'b0}}};
      dv_d[0]  <= den[DENW-1] ? DENW'(-den) : DENW'(den);
      dv_r1[0] <= '0;
      dv_r2[0] <= '0;
      dv_q1[0] <= '0;
      dv_q2[0] <= '0;
    end
  end

  for (genvar j = 0; j < DVN; j++) begin : g_div
    logic [DENW:0] s1, s2, dd;
    assign s1 = {dv_r1[j], dv_n1[j][DVN-1]};
    assign s2 = {dv_r2[j], dv_n2[j][DVN-1]};
    assign dd = {1'b0, dv_d[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_fl[j+1] <= dv_fl[j];
        dv_d[j+1]  <= dv_d[j];
        dv_n1[j+1] <= dv_n1[j] << 1;
        dv_n2[j+1] <= dv_n2[j] << 1;
        if (s1 >= dd) begin
          dv_r1[j+1] <= DENW'(s1 - dd);
          dv_q1[j+1] <= {dv_q1[j][DVN-2:0], 1'b1};
        end else begin
          dv_r1[j+1] <= DENW'(s1);
          dv_q1[j+1] <= {dv_q1[j][DVN-2:0], 1'b0};
        end
        if (s2 >= dd) begin
          dv_r2[j+1] <= DENW'(s2 - dd);
          dv_q2[j+1] <= {dv_q2[j][DVN-2:0], 1'b1};
        end else begin
          dv_r2[j+1] <= DENW'(s2);
          dv_q2[j+1] <= {dv_q2[j][DVN-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- signed, saturated roots
  function automatic sval_t clamp_q(input logic neg, input logic [DVN-1:0] q);
    if (neg) begin
      if (q > (DVN'(1) << (SW - 1))) return SMIN;
      return -sval_t'(q[SW-1:0]);
    end
    if (q > DVN'(SMAX)) return SMAX;
    return sval_t'(q[SW-1:0]);
  endfunction

  sval_t t1, t2;
  fl_t   fl165;

  always_ff @(posedge clk) begin
    if (en) begin
      t1    <= clamp_q(dv_fl[DVN].neg1, dv_q1[DVN]);
      t2    <= clamp_q(dv_fl[DVN].neg2, dv_q2[DVN]);
      fl165 <= dv_fl[DVN];
    end
  end

  // ---------------------------------------------------------------- nearest root past epsilon
  sval_t sel_t;
  logic  hit166, hit167, hit168;
  logic  v1, v2;

  assign v1 = (t1 > TEPS);
  assign v2 = (t2 > TEPS);

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl165.azero) begin
        hit166 <= fl165.bnz && v1;
        sel_t  <= t1;
      end else begin
        hit166 <= fl165.ok && (v1 || v2);
        if (v1 && v2)  sel_t <= (t1 < t2) ? t1 : t2;
        else if (v1)   sel_t <= t1;
        else           sel_t <= t2;
      end
      hit167 <= hit166;
      hit168 <= hit167;
    end
  end

  // ---------------------------------------------------------------- hit point
  sval_t px, py, pz;

  rqi_qmul u_mul_x (.clk(clk), .en(en), .a(sel_t), .b(BW'(ray_p[ST_SEL].ux)), .p(px));
  rqi_qmul u_mul_y (.clk(clk), .en(en), .a(sel_t), .b(BW'(ray_p[ST_SEL].uy)), .p(py));
  rqi_qmul u_mul_z (.clk(clk), .en(en), .a(sel_t), .b(BW'(ray_p[ST_SEL].uz)), .p(pz));

  function automatic logic signed [CW-1:0] to_coord(input sval_t v);
    if (v > SW'(CMAX)) return CMAX;
    if (v < SW'(CMIN)) return CMIN;
    return v[CW-1:0];
  endfunction

  // output register, zero coordinates on a miss
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser[0] <= hit168;
      if (hit168) begin
        m_axis_tdata[0*CW +: CW] <= to_coord(sadd(SW'(ray_p[ST_OUT-1].ox), px));
        m_axis_tdata[1*CW +: CW] <= to_coord(sadd(SW'(ray_p[ST_OUT-1].oy), py));
        m_axis_tdata[2*CW +: CW] <= to_coord(sadd(SW'(ray_p[ST_OUT-1].oz), pz));
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end

endmodule

### hdl/rqi_qmul.sv
// two-stage fixed point multiplier: floor of product, saturated to the intermediate range
module rqi_qmul (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [rqi_pkg::SW-1:0] a,
  input  logic signed [rqi_pkg::BW-1:0] b,
  output logic signed [rqi_pkg::SW-1:0] p
);
  import rqi_pkg::*;

  localparam int LW = 32;
  localparam int HW = SW - LW;
  localparam int FW = SW + BW;
  localparam int TW = FW - FB;

  logic signed [LW+BW:0]   pl;
  logic signed [HW+BW-1:0] ph;
  logic signed [FW-1:0]    full;
  logic        [TW-1:0]    sh;
  logic        [TW-SW:0]   upper;

  // split the wide operand so each product stays near 32 by 32
  always_ff @(posedge clk) begin
    if (en) begin
      pl <= $signed({1'b0, a[LW-1:0]}) * b;
      ph <= $signed(a[SW-1:LW]) * b;
    end
  end

  always_comb begin
    full  = (FW'(ph) <<< LW) + FW'(pl);
    sh    = full[FW-1:FB];
    upper = sh[TW-1:SW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if ((&upper) || !(|upper)) p <= sh[SW-1:0];
      else                       p <= sh[TW-1] ? SMIN : SMAX;
    end
  end

endmodule
